@@ sv/hmtq_pkg.sv @@
// Shared types and constants for the heightmap triangle height query unit.
package hmtq_pkg;

    localparam int COORD_W  = 32;
    localparam int HEIGHT_W = 16;
    localparam int CFG_AW   = 4;

    typedef enum logic [1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Z = 2'd1,
        REG_INV_CELL = 2'd2
    } t_reg_idx;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [16:0] ONE_Q16        = 17'h1_0000;
    localparam logic [31:0] INV_CELL_RESET = 32'h0001_0000;

    typedef struct packed {
        logic x0;
        logic x1;
        logic z0;
        logic z1;
    } t_in_grid;

endpackage

@@ sv/hmtq_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module hmtq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/heightmap_triangle_height_query_unit.sv @@
// Heightmap triangle height query unit: sample store and barycentric height pipeline.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  item in  | i_in_valid / o_in_ready, i_kind .. world | in
//  result   | o_out_valid / i_out_ready, o_height      | out
//  config   | psel penable pwrite paddr pwdata prdata  | in/out
//
// One transaction per cycle unless stalled; a query passes stages 1-5 and the output reg.
// Samples live in four RAM banks split by row and column parity, so the four
// corners of a cell are read together, one read port per bank.
// The store is undefined after reset; no clearing pass. Reset clears origins and valids.
// A held result stalls the whole pipeline; loads write their bank in stage 3.
module heightmap_triangle_height_query_unit #(
    parameter int MAP_COLS = 256,
    parameter int MAP_ROWS = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_kind,
    input  logic [7:0]                             i_sample_col,
    input  logic [7:0]                             i_sample_row,
    input  logic signed [hmtq_pkg::HEIGHT_W-1:0]   i_sample_value,
    input  logic signed [hmtq_pkg::COORD_W-1:0]    i_world_x,
    input  logic signed [hmtq_pkg::COORD_W-1:0]    i_world_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [hmtq_pkg::HEIGHT_W-1:0]   o_height,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [hmtq_pkg::CFG_AW-1:0]            paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    import hmtq_pkg::*;

    localparam int CB         = $clog2(MAP_COLS);
    localparam int RB         = $clog2(MAP_ROWS);
    localparam int HCW        = (CB > 1) ? CB - 1 : 1;
    localparam int HRW        = (RB > 1) ? RB - 1 : 1;
    localparam int BANK_AW    = HCW + HRW;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    localparam logic signed [33:0] COL_LIM0 = 34'(MAP_COLS);
    localparam logic signed [33:0] COL_LIM1 = 34'(MAP_COLS - 1);
    localparam logic signed [33:0] ROW_LIM0 = 34'(MAP_ROWS);
    localparam logic signed [33:0] ROW_LIM1 = 34'(MAP_ROWS - 1);
    localparam logic signed [33:0] MINUS1   = -34'sd1;

    // config
    logic signed [31:0] r_origin_x;
    logic signed [31:0] r_origin_z;
    logic [31:0]        r_inv_cell;
    logic               cfg_wr;

    // flow control
    logic en;
    logic in_acc;

    // stage 1
    logic                r_s1_valid;
    logic                r_s1_kind;
    logic [7:0]          r_s1_col;
    logic [7:0]          r_s1_row;
    logic [15:0]         r_s1_value;
    logic signed [32:0]  r_off_x;
    logic signed [32:0]  r_off_z;
    logic signed [32:0]  n_off_x;
    logic signed [32:0]  n_off_z;

    // stage 2
    logic                r_s2_valid;
    logic                r_s2_kind;
    logic [7:0]          r_s2_col;
    logic [7:0]          r_s2_row;
    logic [15:0]         r_s2_value;
    logic signed [49:0]  r_px_hi;
    logic signed [49:0]  r_pz_hi;
    logic [47:0]         r_px_lo;
    logic [47:0]         r_pz_lo;
    logic signed [16:0]  offx_hi;
    logic signed [16:0]  offz_hi;
    logic signed [32:0]  inv_s;
    logic signed [49:0]  n_px_hi;
    logic signed [49:0]  n_pz_hi;
    logic [47:0]         n_px_lo;
    logic [47:0]         n_pz_lo;

    // stage 3
    logic                r_s3_valid;
    logic                r_s3_kind;
    logic [7:0]          r_s3_col;
    logic [7:0]          r_s3_row;
    logic [15:0]         r_s3_value;
    logic signed [33:0]  r_cx;
    logic signed [33:0]  r_cz;
    logic [15:0]         r_fx;
    logic [15:0]         r_fz;
    logic signed [49:0]  n_qx;
    logic signed [49:0]  n_qz;

    // bank access
    t_in_grid            n_grid;
    logic [HCW-1:0]      hc_even;
    logic [HCW-1:0]      hc_odd;
    logic [HRW-1:0]      hr_even;
    logic [HRW-1:0]      hr_odd;
    logic [HCW:0]        wc_h;
    logic [HRW:0]        wr_h;
    logic                load_ok;
    logic [1:0]          wbank;
    logic [BANK_AW-1:0]  waddr;
    logic [BANK_AW-1:0]  raddr [4];
    logic [15:0]         rdata [4];

    // stage 4
    logic                r_s4_valid;
    logic                r_px;
    logic                r_pz;
    t_in_grid            r_grid;
    logic [15:0]         r_s4_fx;
    logic [15:0]         r_s4_fz;
    logic signed [15:0]  h00;
    logic signed [15:0]  h10;
    logic signed [15:0]  h01;
    logic signed [15:0]  h11;
    logic [16:0]         fsum;
    logic                lower;
    logic [16:0]         wa;
    logic [16:0]         wb;
    logic [16:0]         wc;
    logic signed [15:0]  ha;
    logic signed [33:0]  n_pa;
    logic signed [33:0]  n_pb;
    logic signed [33:0]  n_pc;

    // stage 5 and output
    logic                r_s5_valid;
    logic signed [33:0]  r_pa;
    logic signed [33:0]  r_pb;
    logic signed [33:0]  r_pc;
    logic signed [35:0]  wsum;
    logic signed [35:0]  biased;
    logic signed [19:0]  res;
    logic [15:0]         n_height;
    logic                r_out_valid;
    logic [15:0]         r_height;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_z <= '0;
            r_inv_cell <= INV_CELL_RESET;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_ORIGIN_X: r_origin_x <= pwdata;
                REG_ORIGIN_Z: r_origin_z <= pwdata;
                REG_INV_CELL: r_inv_cell <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_ORIGIN_X: prdata = r_origin_x;
            REG_ORIGIN_Z: prdata = r_origin_z;
            REG_INV_CELL: prdata = r_inv_cell;
            default:      prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign in_acc     = i_in_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= in_acc;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid && (r_s3_kind == KIND_QUERY);
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
        end
    end

    // ---------------- stage 1: offset from origin ----------------
    assign n_off_x = $signed({i_world_x[31], i_world_x}) - $signed({r_origin_x[31], r_origin_x});
    assign n_off_z = $signed({i_world_z[31], i_world_z}) - $signed({r_origin_z[31], r_origin_z});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind  <= i_kind;
            r_s1_col   <= i_sample_col;
            r_s1_row   <= i_sample_row;
            r_s1_value <= i_sample_value;
            r_off_x    <= n_off_x;
            r_off_z    <= n_off_z;
        end
    end

    // ---------------- stage 2: partial products of offset * reciprocal ----------------
    assign offx_hi = r_off_x[32:16];
    assign offz_hi = r_off_z[32:16];
    assign inv_s   = $signed({1'b0, r_inv_cell});
    assign n_px_hi = offx_hi * inv_s;
    assign n_pz_hi = offz_hi * inv_s;
    assign n_px_lo = r_off_x[15:0] * r_inv_cell;
    assign n_pz_lo = r_off_z[15:0] * r_inv_cell;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_col   <= r_s1_col;
            r_s2_row   <= r_s1_row;
            r_s2_value <= r_s1_value;
            r_px_hi    <= n_px_hi;
            r_pz_hi    <= n_pz_hi;
            r_px_lo    <= n_px_lo;
            r_pz_lo    <= n_pz_lo;
        end
    end

    // ---------------- stage 3: grid position, floor at 16 fraction bits ----------------
    assign n_qx = r_px_hi + $signed({2'b00, r_px_lo[47:16]});
    assign n_qz = r_pz_hi + $signed({2'b00, r_pz_lo[47:16]});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_kind  <= r_s2_kind;
            r_s3_col   <= r_s2_col;
            r_s3_row   <= r_s2_row;
            r_s3_value <= r_s2_value;
            r_cx       <= n_qx[49:16];
            r_cz       <= n_qz[49:16];
            r_fx       <= n_qx[15:0];
            r_fz       <= n_qz[15:0];
        end
    end

    // bank {row parity, col parity}; even/odd half index of the two columns and rows
    assign hc_odd  = r_cx[HCW:1];
    assign hc_even = r_cx[HCW:1] + HCW'(r_cx[0]);
    assign hr_odd  = r_cz[HRW:1];
    assign hr_even = r_cz[HRW:1] + HRW'(r_cz[0]);

    assign n_grid.x0 = (r_cx >= 34'sd0) && (r_cx < COL_LIM0);
    assign n_grid.x1 = (r_cx >= MINUS1) && (r_cx < COL_LIM1);
    assign n_grid.z0 = (r_cz >= 34'sd0) && (r_cz < ROW_LIM0);
    assign n_grid.z1 = (r_cz >= MINUS1) && (r_cz < ROW_LIM1);

    assign wc_h    = (HCW + 1)'(r_s3_col);
    assign wr_h    = (HRW + 1)'(r_s3_row);
    assign load_ok = ({24'd0, r_s3_col} < 32'(MAP_COLS)) && ({24'd0, r_s3_row} < 32'(MAP_ROWS));
    assign wbank   = {r_s3_row[0], r_s3_col[0]};
    assign waddr   = {wr_h[HRW:1], wc_h[HCW:1]};

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic RPAR = 1'(b >> 1);
        localparam logic CPAR = 1'(b);

        assign raddr[b] = {(RPAR ? hr_odd : hr_even), (CPAR ? hc_odd : hc_even)};

        hmtq_ram #(
            .WIDTH (HEIGHT_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (en && r_s3_valid && (r_s3_kind == KIND_LOAD) && load_ok
                      && (wbank == 2'(b))),
            .i_waddr (waddr),
            .i_wdata (r_s3_value),
            .i_re    (en),
            .i_raddr (raddr[b]),
            .o_rdata (rdata[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px    <= r_cx[0];
            r_pz    <= r_cz[0];
            r_grid  <= n_grid;
            r_s4_fx <= r_fx;
            r_s4_fz <= r_fz;
        end
    end

    // ---------------- stage 4: corner select, weights, products ----------------
    assign h00 = (r_grid.x0 && r_grid.z0) ? rdata[{r_pz, r_px}]   : '0;
    assign h10 = (r_grid.x1 && r_grid.z0) ? rdata[{r_pz, ~r_px}]  : '0;
    assign h01 = (r_grid.x0 && r_grid.z1) ? rdata[{~r_pz, r_px}]  : '0;
    assign h11 = (r_grid.x1 && r_grid.z1) ? rdata[{~r_pz, ~r_px}] : '0;

    assign fsum  = {1'b0, r_s4_fx} + {1'b0, r_s4_fz};
    assign lower = (fsum <= ONE_Q16);
    assign wa    = lower ? (ONE_Q16 - fsum) : (fsum - ONE_Q16);
    assign wb    = lower ? {1'b0, r_s4_fx} : (ONE_Q16 - {1'b0, r_s4_fz});
    assign wc    = lower ? {1'b0, r_s4_fz} : (ONE_Q16 - {1'b0, r_s4_fx});
    assign ha    = lower ? h00 : h11;

    assign n_pa = $signed({1'b0, wa}) * ha;
    assign n_pb = $signed({1'b0, wb}) * h10;
    assign n_pc = $signed({1'b0, wc}) * h01;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_pc <= n_pc;
        end
    end

    // ---------------- stage 5: sum, round half up, clamp ----------------
    assign wsum   = 36'(r_pa) + 36'(r_pb) + 36'(r_pc);
    assign biased = wsum + 36'sd32768;
    assign res    = biased[35:16];

    always_comb begin
        if (res > 20'sd32767) begin
            n_height = 16'h7FFF;
        end else if (res < -20'sd32768) begin
            n_height = 16'h8000;
        end else begin
            n_height = res[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_height <= n_height;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_height    = r_height;

endmodule

@@ bench/tb_heightmap_triangle_height_query_unit.sv @@
// Self-checking testbench for the heightmap triangle height query unit.
`timescale 1ns / 1ps

module tb_heightmap_triangle_height_query_unit;
    import hmtq_pkg::*;

    localparam int MAP_COLS      = 256;
    localparam int MAP_ROWS      = 256;
    localparam int REG_SPARE_IDX = 3;
    localparam int LOAD_SETTLE   = 12;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic        kind;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] val;
        logic [31:0] wx;
        logic [31:0] wz;
        logic        chk;
        logic [15:0] want;
    } t_stim_row;

    localparam t_stim_row DIRECTED [22] = '{
        '{KIND_LOAD,  8'd0,   8'd0,   16'h0100, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0},
        '{KIND_LOAD,  8'd1,   8'd0,   16'h0300, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0},
        '{KIND_LOAD,  8'd0,   8'd1,   16'h0500, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0},
        '{KIND_LOAD,  8'd1,   8'd1,   16'h0700, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'h0100},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h0000_8000, 32'h0000_8000, 1'b0, 16'h0},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h0000_8000, 32'h0000_8001, 1'b0, 16'h0},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h0000_FFFF, 32'h0000_FFFF, 1'b0, 16'h0},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'hFFFF_8000, 32'h0000_4000, 1'b0, 16'h0},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h0000_4000, 32'hFFFF_FFFF, 1'b0, 16'h0},
        '{KIND_LOAD,  8'd255, 8'd255, 16'h7FFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h00FF_0000, 32'h00FF_0000, 1'b1, 16'h7FFF},
        '{KIND_LOAD,  8'd1,   8'd255, 16'h1234, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0},
        '{KIND_LOAD,  8'd0,   8'd255, 16'h8000, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h0000_0000, 32'h00FF_0000, 1'b1, 16'h8000},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'h0000},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 16'h0000},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'h0000},
        '{KIND_LOAD,  8'd0,   8'd0,   16'hFF00, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'hFF00},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h0000_C000, 32'h0000_2000, 1'b0, 16'h0},
        '{KIND_QUERY, 8'd0,   8'd0,   16'h0000, 32'h00FF_8000, 32'h00FF_0000, 1'b0, 16'h0}
    };

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_ready;
    logic                       i_kind         = KIND_LOAD;
    logic [7:0]                 i_sample_col   = '0;
    logic [7:0]                 i_sample_row   = '0;
    logic signed [HEIGHT_W-1:0] i_sample_value = '0;
    logic signed [COORD_W-1:0]  i_world_x      = '0;
    logic signed [COORD_W-1:0]  i_world_z      = '0;
    logic                       o_out_valid;
    logic                       i_out_ready    = 1'b0;
    logic signed [HEIGHT_W-1:0] o_height;
    logic                       psel           = 1'b0;
    logic                       penable        = 1'b0;
    logic                       pwrite         = 1'b0;
    logic [CFG_AW-1:0]          paddr          = '0;
    logic [31:0]                pwdata         = '0;
    logic [31:0]                prdata;
    logic                       pready;

    logic signed [15:0] height_map [MAP_COLS*MAP_ROWS];
    bit                 height_set [MAP_COLS*MAP_ROWS];
    logic [31:0]        cfg_origin_x = '0;
    logic [31:0]        cfg_origin_z = '0;
    logic [31:0]        cfg_inv      = INV_CELL_RESET;

    logic signed [15:0] pending_heights [$];
    logic signed [15:0] oldest_height;
    int                 errors     = 0;
    int                 items_sent = 0;
    int                 send_idle  = 25;
    int                 recv_idle  = 68;

    heightmap_triangle_height_query_unit #(
        .MAP_COLS(MAP_COLS),
        .MAP_ROWS(MAP_ROWS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_sample_col   (i_sample_col),
        .i_sample_row   (i_sample_row),
        .i_sample_value (i_sample_value),
        .i_world_x      (i_world_x),
        .i_world_z      (i_world_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_height       (o_height),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // grid position of one axis: floor((w - org) * inv) split into cell and Q0.16 fraction
    function automatic void grid_pos(input logic [31:0] w, input logic [31:0] org,
                                     output longint grid_idx, output longint frac);
        logic signed [32:0] off;
        logic signed [65:0] prod;
        off      = $signed({w[31], w}) - $signed({org[31], org});
        prod     = off * $signed({1'b0, cfg_inv});
        grid_idx = longint'(prod >>> 32);
        frac     = longint'(prod[31:16]);
    endfunction

    function automatic longint sample_at(input longint c, input longint r);
        if (c < 0 || c >= MAP_COLS || r < 0 || r >= MAP_ROWS)
            return 0;
        return longint'(height_map[r*MAP_COLS + c]);
    endfunction

    function automatic logic signed [15:0] terrain_height(input logic [31:0] x,
                                                          input logic [31:0] z);
        longint cx, cz, fx, fz, h10, h01, sum, res, one;
        one = longint'(ONE_Q16);
        grid_pos(x, cfg_origin_x, cx, fx);
        grid_pos(z, cfg_origin_z, cz, fz);
        h10 = sample_at(cx + 1, cz);
        h01 = sample_at(cx, cz + 1);
        if (fx + fz <= one)
            sum = (one - fx - fz) * sample_at(cx, cz) + fx * h10 + fz * h01;
        else
            sum = (one - fz) * h10 + (one - fx) * h01 + (fx + fz - one) * sample_at(cx + 1, cz + 1);
        res = (sum + 32768) >>> 16;
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        return res[15:0];
    endfunction

    // world coordinate that lands near grid cells lo .. lo+span-1
    function automatic logic [31:0] aim(input logic [31:0] org, input int lo, input int span);
        longint px, off, w;
        if (cfg_inv == 0)
            return $urandom;
        px  = longint'(lo) * 65536 + longint'($urandom_range(span * 65536 - 1));
        off = (px <<< 16) / longint'(cfg_inv);
        w   = longint'($signed(org)) + off;
        if (w < -64'sd2147483648 || w > 64'sd2147483647)
            return $urandom;
        return w[31:0];
    endfunction

    task automatic send_item(input logic k, input logic [7:0] c, input logic [7:0] r,
                             input logic [15:0] v, input logic [31:0] x, input logic [31:0] z,
                             input logic chk, input logic [15:0] want);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_kind         <= k;
        i_sample_col   <= c;
        i_sample_row   <= r;
        i_sample_value <= v;
        i_world_x      <= x;
        i_world_z      <= z;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (k == KIND_LOAD) begin
            if (c < MAP_COLS && r < MAP_ROWS) begin
                height_map[int'(r)*MAP_COLS + int'(c)] = v;
                height_set[int'(r)*MAP_COLS + int'(c)] = 1'b1;
            end
        end else begin
            pending_heights.push_back(chk ? want : terrain_height(x, z));
        end
        items_sent++;
    endtask

    // load every in-grid corner of the query's cell that holds no sample yet
    task automatic fill_cell(input logic [31:0] x, input logic [31:0] z);
        longint cx, cz, fx, fz, c, r;
        grid_pos(x, cfg_origin_x, cx, fx);
        grid_pos(z, cfg_origin_z, cz, fz);
        for (int dr = 0; dr < 2; dr++) begin
            for (int dc = 0; dc < 2; dc++) begin
                c = cx + dc;
                r = cz + dr;
                if (c >= 0 && c < MAP_COLS && r >= 0 && r < MAP_ROWS &&
                    !height_set[r*MAP_COLS + c]) begin
                    send_item(KIND_LOAD, 8'(c), 8'(r), 16'($urandom), $urandom, $urandom,
                              1'b0, 16'h0);
                end
            end
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_heights.size() != 0)
            @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input int idx, input logic [31:0] val);
        logic [31:0] held;
        held = val;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(idx * 4);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_ORIGIN_X: cfg_origin_x = val;
            REG_ORIGIN_Z: cfg_origin_z = val;
            REG_INV_CELL: cfg_inv      = val;
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx > REG_INV_CELL) begin
            psel <= 1'b0;
            return;
        end
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== held) begin
            $error("prdata: expected %08h, got %08h", held, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_heights.size() == 0) begin
                $error("height: expected none, got %0d", o_height);
                errors++;
            end else begin
                oldest_height = pending_heights.pop_front();
                if (o_height !== oldest_height) begin
                    $error("height: expected %0d, got %0d", oldest_height, o_height);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [31:0] ox, oz, inv, qx, qz;
        int          stop_at, mid, roll, win;
        bit          paused;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[n])
            send_item(DIRECTED[n].kind, DIRECTED[n].col, DIRECTED[n].row, DIRECTED[n].val,
                      DIRECTED[n].wx, DIRECTED[n].wz, DIRECTED[n].chk, DIRECTED[n].want);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin ox = 32'h0; oz = 32'h0; inv = 32'h0001_0000; win = 0; end
                1: begin
                    ox = 32'hFFFD_1234; oz = 32'h0005_0000; inv = 32'h0002_0000; win = 120;
                end
                2: begin ox = 32'h8000_0000; oz = 32'h7FFF_FFFF; inv = 32'h1; win = 0; end
                3: begin ox = $urandom; oz = $urandom; inv = 32'hFFFF_FFFF; win = 0; end
                4: begin
                    ox  = $urandom_range(32'h0200_0000) - 32'h0100_0000;
                    oz  = $urandom_range(32'h0200_0000) - 32'h0100_0000;
                    inv = $urandom_range(32'h0010_0000, 32'h0000_1000);
                    win = $urandom_range(250);
                end
                default: begin ox = $urandom; oz = $urandom; inv = 32'h0; win = 250; end
            endcase
            settle();
            send_idle = (p < 2) ? 25 : (p < 4) ? 68 : 0;
            recv_idle = (p < 2) ? 68 : (p < 4) ? 25 : 0;
            cfg_write(REG_ORIGIN_X, ox);
            cfg_write(REG_ORIGIN_Z, oz);
            cfg_write(REG_INV_CELL, inv);
            if (p == 5)
                cfg_write(REG_SPARE_IDX, $urandom);

            stop_at = items_sent + PHASE_ITEMS;
            mid     = items_sent + PHASE_ITEMS / 2;
            paused  = 1'b0;
            while (items_sent < stop_at) begin
                if (!paused && items_sent >= mid) begin
                    settle();
                    paused = 1'b1;
                end
                roll = $urandom_range(99);
                if (roll < 15) begin
                    send_item(KIND_LOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                              $urandom, $urandom, 1'b0, 16'h0);
                end else begin
                    if (roll < 30) begin
                        qx = $urandom;
                        qz = $urandom;
                    end else if (roll < 45) begin
                        qx = aim(cfg_origin_x, -1, 259);
                        qz = aim(cfg_origin_z, -1, 259);
                    end else begin
                        qx = aim(cfg_origin_x, win - 1, 8);
                        qz = aim(cfg_origin_z, win - 1, 8);
                    end
                    fill_cell(qx, qz);
                    send_item(KIND_QUERY, 8'($urandom), 8'($urandom), 16'($urandom),
                              qx, qz, 1'b0, 16'h0);
                end
            end
        end

        settle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
